[hw/rtl/pcc_pkg.sv]
package pcc_pkg;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned FILTER_W = 16;
	localparam int unsigned ALPHA_W  = 8;
	localparam int unsigned THR_W    = 12;
	localparam int unsigned DUTY_W   = 10;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 12;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_BUTTON = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		ST_NC        = 5'b00001,
		ST_CONNECTED = 5'b00010,
		ST_CHARGE    = 5'b00100,
		ST_ERROR     = 5'b01000,
		ST_DISABLED  = 5'b10000
	} state_t;

	localparam logic [MODE_W-1:0] MODE_NC        = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CONNECTED = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CHARGE    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ERROR     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DISABLED  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONNECT_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONNECT_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_HIGH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT_BELOW  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNPLUG_LOW   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNPLUG_HIGH  = 3'd7;

	localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA = 8'd13;
	localparam logic [THR_W-1:0]   RST_CONNECT_LOW  = 12'd2111;
	localparam logic [THR_W-1:0]   RST_CONNECT_HIGH = 12'd2674;
	localparam logic [THR_W-1:0]   RST_CHARGE_LOW   = 12'd1267;
	localparam logic [THR_W-1:0]   RST_CHARGE_HIGH  = 12'd1830;
	localparam logic [THR_W-1:0]   RST_FAULT_BELOW  = 12'd281;
	localparam logic [THR_W-1:0]   RST_UNPLUG_LOW   = 12'd2955;
	localparam logic [THR_W-1:0]   RST_UNPLUG_HIGH  = 12'd3518;

	localparam logic [FILTER_W-1:0] FILTER_RESET = 16'd19859;
	localparam logic [DUTY_W-1:0]   DUTY_OFF     = 10'd0;
	localparam logic [DUTY_W-1:0]   DUTY_CONNECT = 10'd510;

	typedef struct packed {
		logic [ALPHA_W-1:0] filter_alpha;
		logic [THR_W-1:0]   connect_low;
		logic [THR_W-1:0]   connect_high;
		logic [THR_W-1:0]   charge_low;
		logic [THR_W-1:0]   charge_high;
		logic [THR_W-1:0]   fault_below;
		logic [THR_W-1:0]   unplug_low;
		logic [THR_W-1:0]   unplug_high;
	} cfg_t;

	typedef struct packed {
		action_t             action;
		logic [SAMPLE_W-1:0] adc_sample;
		logic                button_level;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic                relay_on;
		logic [DUTY_W-1:0]   pilot_duty;
		logic [SAMPLE_W-1:0] filtered_level;
		logic                mode_changed;
	} result_t;

	function automatic logic [MODE_W-1:0] mode_code(input state_t s);
		logic [MODE_W-1:0] m;
		unique case (s)
			ST_NC:        m = MODE_NC;
			ST_CONNECTED: m = MODE_CONNECTED;
			ST_CHARGE:    m = MODE_CHARGE;
			ST_ERROR:     m = MODE_ERROR;
			default:      m = MODE_DISABLED;
		endcase
		return m;
	endfunction

endpackage

[hw/rtl/pcc_cfg.sv]
module pcc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pcc_pkg::cfg_t                     cfg
);

	pcc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_alpha <= pcc_pkg::RST_FILTER_ALPHA;
			cfg_q.connect_low  <= pcc_pkg::RST_CONNECT_LOW;
			cfg_q.connect_high <= pcc_pkg::RST_CONNECT_HIGH;
			cfg_q.charge_low   <= pcc_pkg::RST_CHARGE_LOW;
			cfg_q.charge_high  <= pcc_pkg::RST_CHARGE_HIGH;
			cfg_q.fault_below  <= pcc_pkg::RST_FAULT_BELOW;
			cfg_q.unplug_low   <= pcc_pkg::RST_UNPLUG_LOW;
			cfg_q.unplug_high  <= pcc_pkg::RST_UNPLUG_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pcc_pkg::REG_FILTER_ALPHA: cfg_q.filter_alpha <= cfg_data[pcc_pkg::ALPHA_W-1:0];
				pcc_pkg::REG_CONNECT_LOW:  cfg_q.connect_low  <= cfg_data;
				pcc_pkg::REG_CONNECT_HIGH: cfg_q.connect_high <= cfg_data;
				pcc_pkg::REG_CHARGE_LOW:   cfg_q.charge_low   <= cfg_data;
				pcc_pkg::REG_CHARGE_HIGH:  cfg_q.charge_high  <= cfg_data;
				pcc_pkg::REG_FAULT_BELOW:  cfg_q.fault_below  <= cfg_data;
				pcc_pkg::REG_UNPLUG_LOW:   cfg_q.unplug_low   <= cfg_data;
				pcc_pkg::REG_UNPLUG_HIGH:  cfg_q.unplug_high  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/pcc_core.sv]
module pcc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pcc_pkg::item_t   item,
	input  pcc_pkg::cfg_t    cfg,
	output pcc_pkg::result_t result
);

	pcc_pkg::state_t               state_q, state_d;
	logic [pcc_pkg::FILTER_W-1:0]  filter_q, filter_d;
	logic                          relay_q, relay_d;
	logic [pcc_pkg::DUTY_W-1:0]    duty_q, duty_d;
	logic                          button_q, button_d;

	logic signed [pcc_pkg::FILTER_W:0]    diff;
	logic signed [pcc_pkg::FILTER_W+9:0]  acc;
	logic                                 in_connect, in_charge, in_unplug, below_fault;

	// Window bounds are in whole counts; the filter carries four fraction bits.
	function automatic logic in_window(
		input logic [pcc_pkg::THR_W-1:0]    lo,
		input logic [pcc_pkg::THR_W-1:0]    hi,
		input logic [pcc_pkg::FILTER_W-1:0] f
	);
		return ({lo, 4'b0000} < f) && (f < {hi, 4'b0000});
	endfunction

	// (a*s + (256-a)*f) rewritten as 256*f + a*(s-f), so one multiplier serves.
	assign diff = $signed({1'b0, item.adc_sample, 4'b0000}) - $signed({1'b0, filter_q});
	assign acc  = $signed({2'b00, filter_q, 8'h80})
		+ $signed({1'b0, cfg.filter_alpha}) * diff;

	assign in_connect  = in_window(cfg.connect_low, cfg.connect_high, filter_q);
	assign in_charge   = in_window(cfg.charge_low, cfg.charge_high, filter_q);
	assign in_unplug   = in_window(cfg.unplug_low, cfg.unplug_high, filter_q);
	assign below_fault = filter_q < {cfg.fault_below, 4'b0000};

	always_comb begin
		state_d  = state_q;
		filter_d = filter_q;
		relay_d  = relay_q;
		duty_d   = duty_q;
		button_d = button_q;
		unique case (item.action)
			pcc_pkg::ACT_SAMPLE: begin
				filter_d = acc[pcc_pkg::FILTER_W+7:8];
			end
			pcc_pkg::ACT_TICK: begin
				unique case (state_q)
					pcc_pkg::ST_NC: begin
						relay_d = 1'b0;
						duty_d  = pcc_pkg::DUTY_OFF;
						if (in_connect)
							state_d = pcc_pkg::ST_CONNECTED;
					end
					pcc_pkg::ST_CONNECTED: begin
						duty_d = pcc_pkg::DUTY_CONNECT;
						if (in_charge)
							state_d = pcc_pkg::ST_CHARGE;
					end
					pcc_pkg::ST_CHARGE: begin
						relay_d = 1'b1;
						// An unplugged level takes precedence over a fault.
						priority if (in_unplug)
							state_d = pcc_pkg::ST_NC;
						else if (below_fault)
							state_d = pcc_pkg::ST_ERROR;
					end
					pcc_pkg::ST_ERROR: begin
						relay_d = 1'b0;
						if (in_unplug)
							state_d = pcc_pkg::ST_NC;
					end
					default: ;
				endcase
			end
			pcc_pkg::ACT_BUTTON: begin
				if (item.button_level && !button_q)
					state_d = pcc_pkg::ST_NC;
				button_d = item.button_level;
			end
			pcc_pkg::ACT_NONE: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pcc_pkg::ST_DISABLED;
			filter_q <= pcc_pkg::FILTER_RESET;
			relay_q  <= 1'b0;
			duty_q   <= pcc_pkg::DUTY_OFF;
			button_q <= 1'b0;
		end else if (step) begin
			state_q  <= state_d;
			filter_q <= filter_d;
			relay_q  <= relay_d;
			duty_q   <= duty_d;
			button_q <= button_d;
		end
	end

	assign result.mode           = pcc_pkg::mode_code(state_d);
	assign result.relay_on       = relay_d;
	assign result.pilot_duty     = duty_d;
	assign result.filtered_level = filter_d[pcc_pkg::FILTER_W-1:4];
	assign result.mode_changed   = state_d != state_q;

endmodule

[hw/rtl/ev_pilot_charge_controller_top.sv]
// Control-pilot controller for an EV charging point.
// Input channel (in_valid/in_stall): each item is an ADC sample of the pilot
// level, a control tick or a connector button level, selected by action.
// Output channel (out_valid/out_stall): exactly one status item per input
// item, in order: mode, relay drive, pilot PWM compare, filtered level and a
// flag telling whether this item changed the mode.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): eight registers,
// alpha first and then the window bounds and fault level in ADC counts.
// cfg_ready is always high; write only while no item is in flight.
// An accepted item is held in the input register, processed by the core
// and its status offered from the result register. One item per cycle is
// sustained while out_stall is low; the filter's single multiply-accumulate
// and the window compares sit between the input register and the result
// register.
// Reset puts the controller in Disabled with the relay open, duty zero and
// the filter at one volt; only a rising button edge leaves Disabled.
// While out_stall is high the status item holds; the input register fills
// and then in_stall rises until the output is taken.
module ev_pilot_charge_controller_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pcc_pkg::ACTION_W-1:0]       action,
	input  logic [pcc_pkg::SAMPLE_W-1:0]       adc_sample,
	input  logic                               button_level,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pcc_pkg::MODE_W-1:0]         mode,
	output logic                               relay_on,
	output logic [pcc_pkg::DUTY_W-1:0]         pilot_duty,
	output logic [pcc_pkg::SAMPLE_W-1:0]       filtered_level,
	output logic                               mode_changed,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	pcc_pkg::cfg_t    cfg;
	pcc_pkg::item_t   item_s1;
	logic             valid_s1;
	pcc_pkg::result_t result;
	pcc_pkg::result_t res_s2;
	logic             valid_s2;
	logic             adv_s2;
	logic             step;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign step     = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	pcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// The item register starts from a known action so the decode never sees an
	// undefined selector before the first item arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else if (in_valid && !in_stall) begin
			item_s1.action       <= pcc_pkg::action_t'(action);
			item_s1.adc_sample   <= adc_sample;
			item_s1.button_level <= button_level;
		end
	end

	pcc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign mode           = res_s2.mode;
	assign relay_on       = res_s2.relay_on;
	assign pilot_duty     = res_s2.pilot_duty;
	assign filtered_level = res_s2.filtered_level;
	assign mode_changed   = res_s2.mode_changed;

endmodule

[hw/rtl/pcc_checker.sv]
module pcc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [pcc_pkg::MODE_W-1:0]         mode,
	input logic                               relay_on,
	input logic [pcc_pkg::DUTY_W-1:0]         pilot_duty,
	input logic [pcc_pkg::SAMPLE_W-1:0]       filtered_level,
	input logic                               mode_changed
);

	// Duty is only ever cleared or set to the connected value.
	a_duty_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pilot_duty == pcc_pkg::DUTY_OFF || pilot_duty == pcc_pkg::DUTY_CONNECT))
		else $error("pilot duty outside its two values");

	// Disabled is only held from reset, so no item can move into it.
	a_disabled_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mode == pcc_pkg::MODE_DISABLED) |-> !mode_changed)
		else $error("mode changed into disabled");

	// The relay is opened before Connected is reached and never closed in Disabled.
	a_relay_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && relay_on) |->
			(mode != pcc_pkg::MODE_CONNECTED && mode != pcc_pkg::MODE_DISABLED))
		else $error("relay closed in a mode that forbids it");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode <= pcc_pkg::MODE_DISABLED))
		else $error("mode code out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(mode) && $stable(relay_on) && $stable(pilot_duty)
			 && $stable(filtered_level) && $stable(mode_changed)))
		else $error("stalled status item changed");

endmodule

bind ev_pilot_charge_controller_top pcc_checker u_pcc_checker (.*);

[dv/ev_pilot_charge_checker.sv]
`timescale 1ns / 100ps

module ev_pilot_charge_checker
	import pcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [ACTION_W-1:0]   action,
	input  logic [SAMPLE_W-1:0]   adc_sample,
	input  logic                  button_level,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [MODE_W-1:0]     mode,
	input  logic                  relay_on,
	input  logic [DUTY_W-1:0]     pilot_duty,
	input  logic [SAMPLE_W-1:0]   filtered_level,
	input  logic                  mode_changed,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           fail_count,
	output int unsigned           awaiting,
	output int unsigned           checked,
	output int unsigned           changes
);

	cfg_t              pilot_cfg;
	logic [MODE_W-1:0] exp_mode;
	logic [FILTER_W-1:0] exp_filter;
	logic              exp_relay;
	logic [DUTY_W-1:0] exp_duty;
	logic              exp_button;
	result_t           status_due[$];

	// Window tests compare the full Q12.4 level with the bounds scaled by 16.
	function automatic logic level_between(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] hi);
		return ({lo, 4'd0} < exp_filter) && (exp_filter < {hi, 4'd0});
	endfunction

	function automatic result_t pilot_step(input item_t it);
		result_t           r;
		logic [MODE_W-1:0] prior;
		logic [31:0]       a;
		logic [31:0]       acc;
		prior = exp_mode;
		a = 32'(pilot_cfg.filter_alpha);
		case (it.action)
			ACT_SAMPLE: begin
				acc = a * {16'd0, it.adc_sample, 4'd0} + (32'd256 - a) * {16'd0, exp_filter}
					+ 32'd128;
				exp_filter = acc[23:8];
			end
			ACT_TICK: begin
				case (exp_mode)
					MODE_NC: begin
						exp_relay = 1'b0;
						exp_duty = DUTY_OFF;
						if (level_between(pilot_cfg.connect_low, pilot_cfg.connect_high))
							exp_mode = MODE_CONNECTED;
					end
					MODE_CONNECTED: begin
						exp_duty = DUTY_CONNECT;
						if (level_between(pilot_cfg.charge_low, pilot_cfg.charge_high))
							exp_mode = MODE_CHARGE;
					end
					MODE_CHARGE: begin
						exp_relay = 1'b1;
						if (exp_filter < {pilot_cfg.fault_below, 4'd0})
							exp_mode = MODE_ERROR;
						// Unplugging takes precedence over a fault seen on the same tick.
						if (level_between(pilot_cfg.unplug_low, pilot_cfg.unplug_high))
							exp_mode = MODE_NC;
					end
					MODE_ERROR: begin
						exp_relay = 1'b0;
						if (level_between(pilot_cfg.unplug_low, pilot_cfg.unplug_high))
							exp_mode = MODE_NC;
					end
					default: begin
					end
				endcase
			end
			ACT_BUTTON: begin
				if (it.button_level && !exp_button)
					exp_mode = MODE_NC;
				exp_button = it.button_level;
			end
			default: begin
			end
		endcase
		r.mode = exp_mode;
		r.relay_on = exp_relay;
		r.pilot_duty = exp_duty;
		r.filtered_level = exp_filter[FILTER_W-1:4];
		r.mode_changed = (exp_mode != prior);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		item_t   step_in;
		if (!arst_n) begin
			pilot_cfg = '{filter_alpha: RST_FILTER_ALPHA, connect_low: RST_CONNECT_LOW,
				connect_high: RST_CONNECT_HIGH, charge_low: RST_CHARGE_LOW,
				charge_high: RST_CHARGE_HIGH, fault_below: RST_FAULT_BELOW,
				unplug_low: RST_UNPLUG_LOW, unplug_high: RST_UNPLUG_HIGH};
			exp_mode = MODE_DISABLED;
			exp_filter = FILTER_RESET;
			exp_relay = 1'b0;
			exp_duty = DUTY_OFF;
			exp_button = 1'b0;
			status_due.delete();
			fail_count = 0;
			checked = 0;
			changes = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FILTER_ALPHA: pilot_cfg.filter_alpha = cfg_data[ALPHA_W-1:0];
					REG_CONNECT_LOW:  pilot_cfg.connect_low = cfg_data;
					REG_CONNECT_HIGH: pilot_cfg.connect_high = cfg_data;
					REG_CHARGE_LOW:   pilot_cfg.charge_low = cfg_data;
					REG_CHARGE_HIGH:  pilot_cfg.charge_high = cfg_data;
					REG_FAULT_BELOW:  pilot_cfg.fault_below = cfg_data;
					REG_UNPLUG_LOW:   pilot_cfg.unplug_low = cfg_data;
					REG_UNPLUG_HIGH:  pilot_cfg.unplug_high = cfg_data;
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				got.mode = mode;
				got.relay_on = relay_on;
				got.pilot_duty = pilot_duty;
				got.filtered_level = filtered_level;
				got.mode_changed = mode_changed;
				if (status_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: status item with none due: mode %0d relay %0b duty %0d level %0d changed %0b",
							$time, got.mode, got.relay_on, got.pilot_duty, got.filtered_level,
							got.mode_changed);
				end else begin
					want = status_due.pop_front();
					checked++;
					if (got.mode_changed === 1'b1)
						changes++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch (expected/actual) mode %0d/%0d relay %0b/%0b duty %0d/%0d level %0d/%0d changed %0b/%0b",
								$time, want.mode, got.mode, want.relay_on, got.relay_on,
								want.pilot_duty, got.pilot_duty, want.filtered_level,
								got.filtered_level, want.mode_changed, got.mode_changed);
					end
				end
			end
			if (in_valid && !in_stall) begin
				step_in.action = action_t'(action);
				step_in.adc_sample = adc_sample;
				step_in.button_level = button_level;
				status_due.push_back(pilot_step(step_in));
			end
		end
		awaiting = status_due.size();
	end

endmodule

[dv/tb_ev_pilot_charge_controller_top.sv]
`timescale 1ns / 100ps

module tb_ev_pilot_charge_controller_top;
	import pcc_pkg::*;

	localparam int unsigned CLK_PERIOD     = 10;
	localparam int unsigned LONG_HOLD      = 400;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned ITEMS_PER_SET  = 150;

	localparam cfg_t CFG_DEFAULT = '{filter_alpha: RST_FILTER_ALPHA,
		connect_low: RST_CONNECT_LOW, connect_high: RST_CONNECT_HIGH,
		charge_low: RST_CHARGE_LOW, charge_high: RST_CHARGE_HIGH,
		fault_below: RST_FAULT_BELOW, unplug_low: RST_UNPLUG_LOW,
		unplug_high: RST_UNPLUG_HIGH};
	// Frozen filter, every window as wide as it goes and a fault at any level.
	localparam cfg_t CFG_OPEN = '{filter_alpha: 8'd0, connect_low: 12'd0,
		connect_high: 12'hFFF, charge_low: 12'd0, charge_high: 12'hFFF,
		fault_below: 12'hFFF, unplug_low: 12'd0, unplug_high: 12'hFFF};
	// Every window empty and no fault level.
	localparam cfg_t CFG_SHUT = '{filter_alpha: 8'hFF, connect_low: 12'hFFF,
		connect_high: 12'd0, charge_low: 12'hFFF, charge_high: 12'd0,
		fault_below: 12'd0, unplug_low: 12'hFFF, unplug_high: 12'd0};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [ACTION_W-1:0]   action;
	logic [SAMPLE_W-1:0]   adc_sample;
	logic                  button_level;
	logic                  out_valid;
	logic                  out_stall;
	logic [MODE_W-1:0]     mode;
	logic                  relay_on;
	logic [DUTY_W-1:0]     pilot_duty;
	logic [SAMPLE_W-1:0]   filtered_level;
	logic                  mode_changed;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned fail_count;
	int unsigned awaiting;
	int unsigned checked;
	int unsigned changes;

	int unsigned gap_pct;
	int unsigned stall_pct;
	logic        hold_go;
	cfg_t        cfg_now;
	int unsigned sent [4];
	int unsigned sent_total;
	int unsigned reg_writes;
	int unsigned settings;
	int unsigned quiet;

	ev_pilot_charge_controller_top i_dut (.*);

	ev_pilot_charge_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// Receiver: random stalls, or one long hold-off when asked for.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles, %0d status items still due",
				WATCHDOG_LIMIT, awaiting);
			$display("tb_ev_pilot_charge_controller_top: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic offer_item(input action_t act, input logic [SAMPLE_W-1:0] smp,
			input logic lvl);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		adc_sample <= smp;
		button_level <= lvl;
		do @(posedge clk); while (in_stall);
		sent[int'(act)]++;
		sent_total++;
	endtask

	task automatic noise_item();
		offer_item(action_t'($urandom_range(3)), 12'($urandom), 1'($urandom));
	endtask

	// Drain the block: stop offering and wait for every status item.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (awaiting == 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_FILTER_ALPHA: cfg_now.filter_alpha = val[ALPHA_W-1:0];
			REG_CONNECT_LOW:  cfg_now.connect_low = val;
			REG_CONNECT_HIGH: cfg_now.connect_high = val;
			REG_CHARGE_LOW:   cfg_now.charge_low = val;
			REG_CHARGE_HIGH:  cfg_now.charge_high = val;
			REG_FAULT_BELOW:  cfg_now.fault_below = val;
			REG_UNPLUG_LOW:   cfg_now.unplug_low = val;
			REG_UNPLUG_HIGH:  cfg_now.unplug_high = val;
			default: begin
			end
		endcase
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(REG_FILTER_ALPHA, {4'd0, c.filter_alpha});
		write_reg(REG_CONNECT_LOW, c.connect_low);
		write_reg(REG_CONNECT_HIGH, c.connect_high);
		write_reg(REG_CHARGE_LOW, c.charge_low);
		write_reg(REG_CHARGE_HIGH, c.charge_high);
		write_reg(REG_FAULT_BELOW, c.fault_below);
		write_reg(REG_UNPLUG_LOW, c.unplug_low);
		write_reg(REG_UNPLUG_HIGH, c.unplug_high);
		settings++;
	endtask

	// Ordered windows as a real charger would have them, now and then with one
	// register scrambled.
	function automatic cfg_t graded_config();
		cfg_t        c;
		int unsigned lvl;
		c.filter_alpha = 8'($urandom_range(255, 24));
		lvl = $urandom_range(300, 50);
		c.fault_below = 12'(lvl);
		lvl += $urandom_range(500, 60);
		c.charge_low = 12'(lvl);
		lvl += $urandom_range(500, 60);
		c.charge_high = 12'(lvl);
		lvl += $urandom_range(500, 60);
		c.connect_low = 12'(lvl);
		lvl += $urandom_range(500, 60);
		c.connect_high = 12'(lvl);
		lvl += $urandom_range(500, 60);
		c.unplug_low = 12'(lvl);
		lvl += $urandom_range(500, 60);
		c.unplug_high = 12'(lvl);
		if ($urandom_range(3) == 0) begin
			case ($urandom_range(6))
				0: c.fault_below = 12'($urandom);
				1: c.charge_low = 12'($urandom);
				2: c.charge_high = 12'($urandom);
				3: c.connect_low = 12'($urandom);
				4: c.connect_high = 12'($urandom);
				5: c.unplug_low = 12'($urandom);
				default: c.unplug_high = 12'($urandom);
			endcase
		end
		return c;
	endfunction

	function automatic logic [SAMPLE_W-1:0] level_in(input logic [THR_W-1:0] lo,
			input logic [THR_W-1:0] hi);
		if (hi > lo + 1)
			return 12'($urandom_range(hi - 1, lo + 1));
		return 12'($urandom);
	endfunction

	// Samples aimed at one window, mixed with ticks and the odd stray item.
	task automatic approach(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] hi);
		int unsigned n;
		int unsigned r;
		n = $urandom_range(10, 2);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 60)
				offer_item(ACT_SAMPLE, level_in(lo, hi), 1'(r));
			else if (r < 92)
				offer_item(ACT_TICK, 12'($urandom), 1'($urandom));
			else
				noise_item();
		end
		offer_item(ACT_TICK, 12'($urandom), 1'($urandom));
	endtask

	task automatic plug_in_session();
		offer_item(ACT_BUTTON, 12'($urandom), 1'b0);
		offer_item(ACT_BUTTON, 12'($urandom), 1'b1);
		approach(cfg_now.connect_low, cfg_now.connect_high);
		approach(cfg_now.charge_low, cfg_now.charge_high);
		case ($urandom_range(3))
			0: begin
				approach(12'd0, cfg_now.fault_below);
				approach(cfg_now.unplug_low, cfg_now.unplug_high);
			end
			1: approach(cfg_now.unplug_low, cfg_now.unplug_high);
			2: begin
				approach(cfg_now.charge_low, cfg_now.charge_high);
				offer_item(ACT_BUTTON, 12'($urandom), 1'b0);
				offer_item(ACT_BUTTON, 12'($urandom), 1'b1);
			end
			default: repeat ($urandom_range(6, 1)) noise_item();
		endcase
	endtask

	task automatic run_traffic(input int unsigned quota);
		int unsigned start;
		logic        paused;
		start = sent_total;
		paused = 1'b0;
		while (sent_total - start < quota) begin
			if (!paused && sent_total - start >= quota / 2) begin
				settle();
				paused = 1'b1;
			end
			if ($urandom_range(99) < 85)
				plug_in_session();
			else
				repeat ($urandom_range(5, 1)) noise_item();
		end
	endtask

	initial begin
		int unsigned k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_SAMPLE;
		adc_sample = '0;
		button_level = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_FILTER_ALPHA;
		cfg_data = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_go = 1'b0;
		cfg_now = CFG_DEFAULT;
		sent = '{default: 0};
		sent_total = 0;
		reg_writes = 0;
		settings = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Out of reset: Disabled ignores ticks until the button rises.
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_NONE, 12'd0, 1'b0);
		offer_item(ACT_SAMPLE, 12'd0, 1'b0);
		offer_item(ACT_BUTTON, 12'd0, 1'b1);
		offer_item(ACT_BUTTON, 12'd0, 1'b1);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		settle();
		// A fast filter and a fault level inside the unplug window, so that a
		// tick in Charge can see both conditions at once.
		write_reg(REG_FILTER_ALPHA, 12'd255);
		write_reg(REG_FAULT_BELOW, 12'd3300);
		offer_item(ACT_SAMPLE, 12'd2400, 1'b0);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_SAMPLE, 12'd1500, 1'b0);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_SAMPLE, 12'd3200, 1'b0);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_SAMPLE, 12'd2400, 1'b0);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_SAMPLE, 12'd1500, 1'b0);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_SAMPLE, 12'd3200, 1'b0);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_SAMPLE, 12'd2400, 1'b0);
		offer_item(ACT_TICK, 12'd0, 1'b0);
		offer_item(ACT_BUTTON, 12'hFFF, 1'b0);
		offer_item(ACT_BUTTON, 12'hFFF, 1'b1);
		offer_item(ACT_SAMPLE, 12'hFFF, 1'b1);
		offer_item(ACT_NONE, 12'hFFF, 1'b1);

		for (k = 0; k < 8; k++) begin
			settle();
			case (k / 2)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 78; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 78; end
				default: begin gap_pct = 20; stall_pct = 20; end
			endcase
			case (k)
				0: load_config(CFG_DEFAULT);
				1: load_config(CFG_OPEN);
				3: begin
					// Alpha is 8 bits wide; the upper data bits must be dropped.
					load_config(CFG_SHUT);
					write_reg(REG_FILTER_ALPHA, 12'hFFF);
				end
				default: load_config(graded_config());
			endcase
			if (k == 0 || k == 4)
				hold_go = 1'b1;
			run_traffic(ITEMS_PER_SET);
		end

		settle();
		repeat (10) @(posedge clk);
		$display("Covered %0d items: %0d samples, %0d ticks, %0d button levels, %0d unused codes.",
			sent_total, sent[0], sent[1], sent[2], sent[3]);
		$display("%0d status items checked, %0d mode changes, %0d register settings, %0d writes.",
			checked, changes, settings, reg_writes);
		if (fail_count == 0 && awaiting == 0)
			$display("tb_ev_pilot_charge_controller_top: clean");
		else
			$display("tb_ev_pilot_charge_controller_top: errors");
		$finish;
	end

endmodule

[files.f]
hw/rtl/pcc_pkg.sv
hw/rtl/pcc_cfg.sv
hw/rtl/pcc_core.sv
hw/rtl/ev_pilot_charge_controller_top.sv
hw/rtl/pcc_checker.sv
dv/ev_pilot_charge_checker.sv
dv/tb_ev_pilot_charge_controller_top.sv
